@@ src/sme_pkg.sv @@
// Shared package for the stack machine evaluator.
// Holds sizes, opcodes, status codes, controller states and command/status structs.
// No dependencies.
package sme_pkg;

   localparam int StackDepth = 256;
   localparam int VarCount   = 64;
   localparam int SpW        = $clog2(StackDepth + 1);
   localparam int SaW        = $clog2(StackDepth);
   localparam int VaW        = $clog2(VarCount);
   localparam int DepthW     = 9;

   localparam logic [3:0] OP_PUSHC  = 4'd0;
   localparam logic [3:0] OP_PUSHV  = 4'd1;
   localparam logic [3:0] OP_ADD    = 4'd2;
   localparam logic [3:0] OP_SUB    = 4'd3;
   localparam logic [3:0] OP_MUL    = 4'd4;
   localparam logic [3:0] OP_DIV    = 4'd5;
   localparam logic [3:0] OP_NEG    = 4'd6;
   localparam logic [3:0] OP_EVAL   = 4'd7;
   localparam logic [3:0] OP_ASSIGN = 4'd8;
   localparam logic [3:0] OP_PRINT  = 4'd9;
   localparam logic [3:0] OP_POP    = 4'd10;

   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_OVER  = 3'd1;
   localparam logic [2:0] ST_UNDER = 3'd2;
   localparam logic [2:0] ST_DIVZ  = 3'd3;
   localparam logic [2:0] ST_UNDEF = 3'd4;

   typedef enum logic [3:0] {
      S_IDLE, S_READ, S_WAIT, S_EXEC, S_VREAD, S_VWAIT, S_MUL, S_MUL2,
      S_DIV, S_FIN, S_OUT
   } state_type;

   typedef struct packed {
      logic rd_top;    // read the two top entries
      logic mul_start;
      logic mul_step;
      logic div_start;
      logic div_step;
      logic wr_res;    // write result at sp-2 (binary) or sp-1 (unary)
      logic res_unary;
      logic [2:0] res_sel; // 0 add 1 sub 2 mul 3 div 4 neg 5 var
      logic wr_push;
      logic wr_var;
   } cmd_type;

   typedef struct packed {
      logic top_zero;
      logic def_flag;
      logic div_done;
   } sts_type;

   localparam logic [2:0] RS_ADD = 3'd0;
   localparam logic [2:0] RS_SUB = 3'd1;
   localparam logic [2:0] RS_MUL = 3'd2;
   localparam logic [2:0] RS_DIV = 3'd3;
   localparam logic [2:0] RS_NEG = 3'd4;
   localparam logic [2:0] RS_VAR = 3'd5;

   function automatic logic [63:0] sat_sign(input logic neg, input logic [64:0] mag);
      if (!neg) return (mag > 65'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : mag[63:0];
      if (mag > 65'h8000_0000_0000_0000) return 64'h8000_0000_0000_0000;
      return 64'(-mag[63:0]);
   endfunction

endpackage

@@ src/sme_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module sme_ram #(
   parameter int Width = 64,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule

@@ src/sme_datapath.sv @@
// Datapath: operand stack and variable memories, arithmetic and the serial divider.
// Depends on sme_pkg and sme_ram.
module sme_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  sme_pkg::cmd_type          cmd,
   input  logic [sme_pkg::SpW-1:0]   sp,
   input  logic [63:0]               push_data,
   output sme_pkg::sts_type          sts,
   output logic [63:0]               top_value
);
   localparam int SpW = sme_pkg::SpW;
   localparam int SaW = sme_pkg::SaW;
   localparam int VaW = sme_pkg::VaW;

   logic [63:0] rd_a, rd_b, vr_data;
   logic [63:0] x_ff, y_ff, res;
   logic [SaW-1:0] ra_addr, rb_addr, wa;
   logic [63:0] wdat;
   logic [SpW-1:0] spm1, spm2;
   logic [sme_pkg::VarCount-1:0] def_ff;
   logic rd_pend_ff;

   assign spm1 = sp - SpW'(1);
   assign spm2 = sp - SpW'(2);
   assign ra_addr = spm1[SaW-1:0];
   assign rb_addr = spm2[SaW-1:0];

   always_comb begin
      if (cmd.wr_push) begin
         wa = sp[SaW-1:0]; wdat = push_data;
      end else begin
         wa = cmd.res_unary ? spm1[SaW-1:0] : spm2[SaW-1:0]; wdat = res;
      end
   end

   sme_ram #(.Width(64), .Depth(sme_pkg::StackDepth)) u_sa (
      .clock, .wr_en(cmd.wr_push | cmd.wr_res), .wr_addr(wa), .wr_data(wdat),
      .rd_addr(ra_addr), .rd_data(rd_a));
   sme_ram #(.Width(64), .Depth(sme_pkg::StackDepth)) u_sb (
      .clock, .wr_en(cmd.wr_push | cmd.wr_res), .wr_addr(wa), .wr_data(wdat),
      .rd_addr(rb_addr), .rd_data(rd_b));
   sme_ram #(.Width(64), .Depth(sme_pkg::VarCount)) u_var (
      .clock, .wr_en(cmd.wr_var), .wr_addr(y_ff[VaW-1:0]), .wr_data(x_ff),
      .rd_addr(y_ff[VaW-1:0]), .rd_data(vr_data));

   always_ff @(posedge clock) begin
      if (reset) begin
         def_ff <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         rd_pend_ff <= cmd.rd_top;
         if (cmd.wr_var) def_ff[y_ff[VaW-1:0]] <= 1'b1;
      end
      if (rd_pend_ff) begin
         y_ff <= rd_a; x_ff <= rd_b;
      end
   end

   // Multiplier: four 32x32 partial products, then a sum.
   logic neg_ff;
   logic [63:0] ma_ff, mb_ff, ll_ff, lh_ff, hl_ff, hh_ff, mul_res_ff;
   logic [64:0] mid, hi;
   logic [63:0] lo;
   always_comb begin
      mid = 65'(ll_ff[63:32]) + 65'(lh_ff[31:0]) + 65'(hl_ff[31:0]);
      lo  = {mid[31:0], ll_ff[31:0]};
      hi  = 65'(hh_ff) + 65'(lh_ff[63:32]) + 65'(hl_ff[63:32]) + 65'(mid[64:32]);
   end
   // Divider: one quotient bit per cycle.
   logic [64:0] r_ff;
   logic [63:0] q_ff, lo_ff;
   logic [6:0]  cnt_ff;
   logic        dsat_ff;
   logic [64:0] r_sh;
   always_comb r_sh = {r_ff[63:0], lo_ff[63]};

   always_ff @(posedge clock) begin
      if (cmd.mul_start || cmd.div_start) begin
         neg_ff <= x_ff[63] ^ y_ff[63];
         ma_ff  <= x_ff[63] ? 64'(-x_ff) : x_ff;
         mb_ff  <= y_ff[63] ? 64'(-y_ff) : y_ff;
      end
      if (cmd.mul_step) begin
         ll_ff <= 64'(ma_ff[31:0]) * 64'(mb_ff[31:0]);
         lh_ff <= 64'(ma_ff[31:0]) * 64'(mb_ff[63:32]);
         hl_ff <= 64'(ma_ff[63:32]) * 64'(mb_ff[31:0]);
         hh_ff <= 64'(ma_ff[63:32]) * 64'(mb_ff[63:32]);
      end
      mul_res_ff <= (hi[64:32] != '0) ? 64'hFFFF_FFFF_FFFF_FFFF : {hi[31:0], lo[63:32]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         if (cnt_ff == 7'd0) begin
            r_ff <= 65'(ma_ff[63:32]); lo_ff <= {ma_ff[31:0], 32'd0};
            q_ff <= '0; dsat_ff <= (ma_ff[63:32] >= mb_ff) ? 1'b1 : 1'b0;
            cnt_ff <= 7'd64;
         end else begin
            lo_ff <= {lo_ff[62:0], 1'b0};
            if (r_sh >= 65'(mb_ff)) begin
               r_ff <= r_sh - 65'(mb_ff); q_ff <= {q_ff[62:0], 1'b1};
            end else begin
               r_ff <= r_sh; q_ff <= {q_ff[62:0], 1'b0};
            end
            cnt_ff <= cnt_ff - 7'd1;
         end
      end
   end

   logic [64:0] s_add, s_sub, s_neg;
   always_comb begin
      s_add = {x_ff[63], x_ff} + {y_ff[63], y_ff};
      s_sub = {x_ff[63], x_ff} - {y_ff[63], y_ff};
      s_neg = 65'd0 - {y_ff[63], y_ff};
      case (cmd.res_sel)
         sme_pkg::RS_ADD: res = (s_add[64] != s_add[63]) ?
            (s_add[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF) : s_add[63:0];
         sme_pkg::RS_SUB: res = (s_sub[64] != s_sub[63]) ?
            (s_sub[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF) : s_sub[63:0];
         sme_pkg::RS_NEG: res = (s_neg[64] != s_neg[63]) ?
            64'h7FFF_FFFF_FFFF_FFFF : s_neg[63:0];
         sme_pkg::RS_MUL: res = sme_pkg::sat_sign(neg_ff, {1'b0, mul_res_ff});
         sme_pkg::RS_DIV: res = sme_pkg::sat_sign(neg_ff,
            dsat_ff ? 65'h0_FFFF_FFFF_FFFF_FFFF : {1'b0, q_ff});
         sme_pkg::RS_VAR: res = vr_data;
         default: res = x_ff;
      endcase
   end

   assign sts.top_zero = (y_ff == 64'd0);
   assign sts.def_flag = def_ff[y_ff[VaW-1:0]];
   assign sts.div_done = cmd.div_step && (cnt_ff == 7'd1);
   assign top_value = y_ff;
endmodule

@@ src/sme_ctrl.sv @@
// Controller state machine: sequences each instruction and tracks the stack pointer.
// Depends on sme_pkg.
module sme_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [3:0]              req_opcode,
   input  logic [63:0]             req_operand_value,
   input  logic [5:0]              req_var_index,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [2:0]              rsp_status,
   output logic                    rsp_print_valid,
   output logic [63:0]             rsp_print_value,
   output logic [8:0]              rsp_stack_depth,
   output sme_pkg::cmd_type        cmd,
   output logic [sme_pkg::SpW-1:0] sp,
   output logic [63:0]             push_data,
   input  sme_pkg::sts_type        sts,
   input  logic [63:0]             top_value
);
   localparam int SpW = sme_pkg::SpW;
   sme_pkg::state_type state_ff, state_in;
   logic [SpW-1:0] sp_ff, sp_in;
   logic [3:0] op_ff;
   logic [63:0] pd_ff;
   logic [2:0] st_ff, st_in;
   logic pv_ff, pv_in;
   logic [63:0] pval_ff, pval_in;

   assign sp = sp_ff;
   assign push_data = pd_ff;
   assign req_ready = (state_ff == sme_pkg::S_IDLE);
   assign rsp_valid = (state_ff == sme_pkg::S_OUT);
   assign rsp_status = st_ff;
   assign rsp_print_valid = pv_ff;
   assign rsp_print_value = pval_ff;
   assign rsp_stack_depth = sme_pkg::DepthW'(sp_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sme_pkg::S_IDLE;
         sp_ff <= '0;
         st_ff <= sme_pkg::ST_OK;
         pv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sp_ff <= sp_in;
         st_ff <= st_in;
         pv_ff <= pv_in;
      end
      pval_ff <= pval_in;
      if (req_valid && req_ready) begin
         op_ff <= req_opcode;
         pd_ff <= (req_opcode == sme_pkg::OP_PUSHV) ?
                  64'(req_var_index[sme_pkg::VaW-1:0]) : req_operand_value;
      end
   end

   always_comb begin
      state_in = state_ff; sp_in = sp_ff; st_in = st_ff; pv_in = pv_ff; pval_in = pval_ff;
      cmd = '0;
      case (state_ff)
         sme_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = sme_pkg::S_READ; st_in = sme_pkg::ST_OK;
               pv_in = 1'b0; pval_in = '0;
            end
         end
         sme_pkg::S_READ: begin
            cmd.rd_top = 1'b1; state_in = sme_pkg::S_WAIT;
         end
         sme_pkg::S_WAIT: state_in = sme_pkg::S_EXEC;
         sme_pkg::S_EXEC: begin
            state_in = sme_pkg::S_FIN;
            case (op_ff)
               sme_pkg::OP_PUSHC, sme_pkg::OP_PUSHV: begin
                  if (sp_ff >= SpW'(sme_pkg::StackDepth)) st_in = sme_pkg::ST_OVER;
                  else begin
                     cmd.wr_push = 1'b1; sp_in = sp_ff + SpW'(1);
                  end
               end
               sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL, sme_pkg::OP_ASSIGN: begin
                  if (sp_ff < SpW'(2)) st_in = sme_pkg::ST_UNDER;
                  else if (op_ff == sme_pkg::OP_ASSIGN) begin
                     cmd.wr_var = 1'b1; sp_in = sp_ff - SpW'(1);
                  end else if (op_ff == sme_pkg::OP_MUL) begin
                     cmd.mul_start = 1'b1; state_in = sme_pkg::S_MUL;
                  end else begin
                     cmd.wr_res = 1'b1;
                     cmd.res_sel = (op_ff == sme_pkg::OP_ADD) ? sme_pkg::RS_ADD : sme_pkg::RS_SUB;
                     sp_in = sp_ff - SpW'(1);
                  end
               end
               sme_pkg::OP_DIV: begin
                  if (sp_ff == '0) st_in = sme_pkg::ST_UNDER;
                  else if (sts.top_zero) st_in = sme_pkg::ST_DIVZ;
                  else if (sp_ff == SpW'(1)) st_in = sme_pkg::ST_UNDER;
                  else begin
                     cmd.div_start = 1'b1; state_in = sme_pkg::S_DIV;
                  end
               end
               sme_pkg::OP_NEG, sme_pkg::OP_EVAL, sme_pkg::OP_PRINT, sme_pkg::OP_POP: begin
                  if (sp_ff == '0) st_in = sme_pkg::ST_UNDER;
                  else if (op_ff == sme_pkg::OP_NEG) begin
                     cmd.wr_res = 1'b1; cmd.res_unary = 1'b1; cmd.res_sel = sme_pkg::RS_NEG;
                  end else if (op_ff == sme_pkg::OP_EVAL) begin
                     if (!sts.def_flag) st_in = sme_pkg::ST_UNDEF;
                     else begin
                        state_in = sme_pkg::S_VREAD;
                     end
                  end else begin
                     if (op_ff == sme_pkg::OP_PRINT) begin
                        pv_in = 1'b1; pval_in = top_value;
                     end
                     sp_in = sp_ff - SpW'(1);
                  end
               end
               default: ;
            endcase
         end
         sme_pkg::S_VREAD: state_in = sme_pkg::S_VWAIT;
         sme_pkg::S_VWAIT: begin
            cmd.wr_res = 1'b1; cmd.res_unary = 1'b1; cmd.res_sel = sme_pkg::RS_VAR;
            state_in = sme_pkg::S_FIN;
         end
         sme_pkg::S_MUL: begin
            cmd.mul_step = 1'b1; state_in = sme_pkg::S_MUL2;
         end
         sme_pkg::S_MUL2: begin
            // Partial products are held; the product register takes their sum at the end of this state.
            state_in = sme_pkg::S_VREAD; cmd.res_sel = sme_pkg::RS_MUL;
         end
         sme_pkg::S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) begin
               cmd.res_sel = sme_pkg::RS_DIV; state_in = sme_pkg::S_VWAIT;
            end
         end
         sme_pkg::S_FIN: begin
            if (st_in != sme_pkg::ST_OK) sp_in = '0;
            state_in = sme_pkg::S_OUT;
         end
         sme_pkg::S_OUT: begin
            if (rsp_ready) state_in = sme_pkg::S_IDLE;
         end
         default: state_in = sme_pkg::S_IDLE;
      endcase
      if (state_ff == sme_pkg::S_VWAIT) begin
         if (op_ff == sme_pkg::OP_MUL) begin
            cmd.res_sel = sme_pkg::RS_MUL; cmd.res_unary = 1'b0; sp_in = sp_ff - SpW'(1);
         end else if (op_ff == sme_pkg::OP_DIV) begin
            cmd.res_sel = sme_pkg::RS_DIV; cmd.res_unary = 1'b0; sp_in = sp_ff - SpW'(1);
         end
      end
   end
endmodule

@@ src/stack_machine_evaluator.sv @@
// Stack machine evaluator top level: controller plus datapath.
// Every instruction passes through the read, wait, execute, finish and output states;
// a successful evaluate, multiply or divide adds states of its own, divide taking one quotient bit a cycle.
// Handshake: one instruction at a time; the next beat is taken after the result beat leaves.
// Reset (synchronous, active high) empties the stack and clears all defined flags.
// Depends on sme_pkg, sme_ctrl and sme_datapath.
module stack_machine_evaluator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_opcode,
   input  logic [63:0] req_operand_value,
   input  logic [5:0]  req_var_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic        rsp_print_valid,
   output logic [63:0] rsp_print_value,
   output logic [8:0]  rsp_stack_depth
);
   sme_pkg::cmd_type cmd;
   sme_pkg::sts_type sts;
   logic [sme_pkg::SpW-1:0] sp;
   logic [63:0] push_data, top_value;

   sme_ctrl u_ctrl (.*);
   sme_datapath u_dp (.clock, .reset, .cmd, .sp, .push_data, .sts, .top_value);

   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready while result pending");
   a_err_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != sme_pkg::ST_OK) |-> rsp_stack_depth == 9'd0)
      else $error("stack not emptied on error");
   a_print: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_print_valid) |-> rsp_status == sme_pkg::ST_OK)
      else $error("print with error");
endmodule

@@ bench/tb_stack_machine_evaluator.sv @@
`timescale 1ns / 1ps
// Self-checking bench for stack_machine_evaluator: directed and random instruction streams
// are predicted by a behavioural stack machine and compared beat by beat. Depends on sme_pkg.
module tb_stack_machine_evaluator;

   localparam logic [63:0] MaxPos = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] MinNeg = 64'h8000_0000_0000_0000;
   localparam logic [63:0] One    = 64'h0000_0001_0000_0000;
   localparam int          IdleLimit = 3000;

   typedef struct {
      logic [2:0]  status;
      logic        print_valid;
      logic [63:0] print_value;
      logic [8:0]  depth;
   } result_type;

   logic        clock, reset;
   logic        req_valid, req_ready;
   logic [3:0]  req_opcode;
   logic [63:0] req_operand_value;
   logic [5:0]  req_var_index;
   logic        rsp_valid, rsp_ready;
   logic [2:0]  rsp_status;
   logic        rsp_print_valid;
   logic [63:0] rsp_print_value;
   logic [8:0]  rsp_stack_depth;

   logic [63:0] stack_m [sme_pkg::StackDepth];
   int          depth_m;
   logic [63:0] vars_m [sme_pkg::VarCount];
   bit          defined_m [sme_pkg::VarCount];

   result_type  pending_q [$];
   int          errors, sent, received, prints, faults;
   bit          calm, long_hold;
   int          idle_cycles;

   stack_machine_evaluator u_top (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [63:0] magnitude(logic [63:0] v);
      return v[63] ? -v : v;
   endfunction

   function automatic logic [63:0] signed_sat(bit neg, logic [64:0] mag);
      if (!neg) return (mag > {1'b0, MaxPos}) ? MaxPos : mag[63:0];
      if (mag > {1'b0, MinNeg}) return MinNeg;
      return -mag[63:0];
   endfunction

   function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
      logic [63:0] r;
      r = a + b;
      if (a[63] == b[63] && r[63] != a[63]) return a[63] ? MinNeg : MaxPos;
      return r;
   endfunction

   function automatic logic [63:0] sub_sat(logic [63:0] a, logic [63:0] b);
      logic [63:0] r;
      r = a - b;
      if (a[63] != b[63] && r[63] != a[63]) return a[63] ? MinNeg : MaxPos;
      return r;
   endfunction

   function automatic logic [63:0] q_mul(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
      if (p[127:96] != 0) return signed_sat(a[63] ^ b[63], {1'b0, {64{1'b1}}});
      return signed_sat(a[63] ^ b[63], {1'b0, p[95:32]});
   endfunction

   function automatic logic [63:0] q_div(logic [63:0] a, logic [63:0] b);
      logic [63:0]  na, nb;
      logic [127:0] q;
      na = magnitude(a);
      nb = magnitude(b);
      if ({32'd0, na[63:32]} >= nb) return signed_sat(a[63] ^ b[63], {1'b0, {64{1'b1}}});
      q = {32'd0, na, 32'd0} / {64'd0, nb};
      return signed_sat(a[63] ^ b[63], {1'b0, q[63:0]});
   endfunction

   function automatic result_type execute(logic [3:0] op, logic [63:0] val, logic [5:0] vix);
      result_type r;
      int         sp, k;
      r  = '{sme_pkg::ST_OK, 1'b0, 64'd0, 9'd0};
      sp = depth_m;
      case (op)
         sme_pkg::OP_PUSHC, sme_pkg::OP_PUSHV: begin
            if (sp >= sme_pkg::StackDepth) r.status = sme_pkg::ST_OVER;
            else begin
               stack_m[sp] = (op == sme_pkg::OP_PUSHC) ? val : 64'(vix % sme_pkg::VarCount);
               sp++;
            end
         end
         sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL, sme_pkg::OP_ASSIGN: begin
            if (sp < 2) r.status = sme_pkg::ST_UNDER;
            else if (op == sme_pkg::OP_ASSIGN) begin
               k = int'(stack_m[sp-1] % sme_pkg::VarCount);
               vars_m[k] = stack_m[sp-2];
               defined_m[k] = 1'b1;
               sp--;
            end else begin
               stack_m[sp-2] = (op == sme_pkg::OP_ADD) ?
                               add_sat(stack_m[sp-2], stack_m[sp-1]) :
                               (op == sme_pkg::OP_SUB) ?
                               sub_sat(stack_m[sp-2], stack_m[sp-1]) :
                               q_mul(stack_m[sp-2], stack_m[sp-1]);
               sp--;
            end
         end
         sme_pkg::OP_DIV: begin
            if (sp == 0) r.status = sme_pkg::ST_UNDER;
            else if (stack_m[sp-1] == 0) r.status = sme_pkg::ST_DIVZ;
            else if (sp == 1) r.status = sme_pkg::ST_UNDER;
            else begin
               stack_m[sp-2] = q_div(stack_m[sp-2], stack_m[sp-1]);
               sp--;
            end
         end
         sme_pkg::OP_NEG, sme_pkg::OP_EVAL, sme_pkg::OP_PRINT, sme_pkg::OP_POP: begin
            if (sp == 0) r.status = sme_pkg::ST_UNDER;
            else if (op == sme_pkg::OP_NEG) stack_m[sp-1] = sub_sat(64'd0, stack_m[sp-1]);
            else if (op == sme_pkg::OP_EVAL) begin
               k = int'(stack_m[sp-1] % sme_pkg::VarCount);
               if (!defined_m[k]) r.status = sme_pkg::ST_UNDEF;
               else stack_m[sp-1] = vars_m[k];
            end else begin
               if (op == sme_pkg::OP_PRINT) begin
                  r.print_valid = 1'b1;
                  r.print_value = stack_m[sp-1];
               end
               sp--;
            end
         end
         default: ;
      endcase
      if (r.status != sme_pkg::ST_OK) sp = 0;
      depth_m = sp;
      r.depth = 9'(sp);
      return r;
   endfunction

   task automatic send_beat(logic [3:0] op, logic [63:0] val, logic [5:0] vix);
      if (!calm && $urandom_range(99) < 20) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_opcode        <= op;
      req_operand_value <= val;
      req_var_index     <= vix;
      do @(posedge clock); while (!req_ready);
      pending_q.push_back(execute(op, val, vix));
      sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_q.size() != 0);
   endtask

   function automatic logic [63:0] pick_value();
      case ($urandom_range(9))
         0: return 64'd0;
         1: return One;
         2: return -One;
         3: return MaxPos;
         4: return MinNeg;
         5, 6: return {32'($signed(8'($urandom))), $urandom_range(3) == 0 ? $urandom : 32'd0};
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic test_directed();
      send_beat(sme_pkg::OP_POP, 64'd0, 6'd0);
      send_beat(sme_pkg::OP_DIV, 64'd0, 6'd0);
      send_beat(sme_pkg::OP_PUSHC, 64'd0, 6'd0);
      send_beat(sme_pkg::OP_DIV, 64'd0, 6'd0);
      send_beat(sme_pkg::OP_PUSHC, One, 6'd0);
      send_beat(sme_pkg::OP_DIV, 64'd0, 6'd0);
      send_beat(sme_pkg::OP_PUSHC, MaxPos, 6'd0);
      send_beat(sme_pkg::OP_PUSHC, MaxPos, 6'd0);
      send_beat(sme_pkg::OP_ADD, 64'd0, 6'd0);
      send_beat(sme_pkg::OP_PUSHC, MinNeg, 6'd0);
      send_beat(sme_pkg::OP_MUL, 64'd0, 6'd0);
      send_beat(sme_pkg::OP_NEG, 64'd0, 6'd0);
      send_beat(sme_pkg::OP_PUSHC, 64'd1, 6'd0);
      send_beat(sme_pkg::OP_DIV, 64'd0, 6'd0);
      send_beat(sme_pkg::OP_PUSHC, MinNeg, 6'd0);
      send_beat(sme_pkg::OP_SUB, 64'd0, 6'd0);
      send_beat(sme_pkg::OP_NEG, 64'd0, 6'd0);
      send_beat(sme_pkg::OP_PUSHV, 64'd0, 6'd63);
      send_beat(sme_pkg::OP_EVAL, 64'd0, 6'd0);
      send_beat(sme_pkg::OP_PUSHC, 64'hFFFF_FFFF_FFFF_FFFF, 6'd0);
      send_beat(sme_pkg::OP_PUSHV, 64'd0, 6'd63);
      send_beat(sme_pkg::OP_ASSIGN, 64'd0, 6'd0);
      send_beat(sme_pkg::OP_PUSHV, 64'd0, 6'd63);
      send_beat(sme_pkg::OP_EVAL, 64'd0, 6'd0);
      send_beat(sme_pkg::OP_PRINT, 64'd0, 6'd0);
      send_beat(4'd15, 64'd0, 6'd0);
      drain();
   endtask

   task automatic test_overflow();
      repeat (sme_pkg::StackDepth + 1)
         send_beat(sme_pkg::OP_PUSHC, pick_value(), 6'($urandom));
      drain();
   endtask

   task automatic test_backpressure();
      long_hold = 1'b1;
      repeat (8) send_beat(sme_pkg::OP_PUSHC, pick_value(), 6'd0);
      while (long_hold) @(posedge clock);
      drain();
   endtask

   task automatic random_op();
      int          r;
      logic [3:0]  op;
      r = $urandom_range(99);
      if (depth_m > 24) r = 90 + $urandom_range(9);
      op = (r < 28) ? sme_pkg::OP_PUSHC : (r < 36) ? sme_pkg::OP_PUSHV :
           (r < 46) ? sme_pkg::OP_ADD : (r < 52) ? sme_pkg::OP_SUB :
           (r < 60) ? sme_pkg::OP_MUL : (r < 68) ? sme_pkg::OP_DIV :
           (r < 72) ? sme_pkg::OP_NEG : (r < 80) ? sme_pkg::OP_EVAL :
           (r < 86) ? sme_pkg::OP_ASSIGN : (r < 93) ? sme_pkg::OP_PRINT :
           (r < 98) ? sme_pkg::OP_POP : 4'($urandom_range(15, 11));
      send_beat(op, pick_value(), 6'($urandom));
   endtask

   task automatic test_random(int count);
      int          target;
      logic [5:0]  v;
      target = sent + count;
      while (sent < target) begin
         if ($urandom_range(99) < 35) begin
            v = 6'($urandom);
            send_beat(sme_pkg::OP_PUSHC, pick_value(), 6'($urandom));
            send_beat(sme_pkg::OP_PUSHV, {$urandom, $urandom}, v);
            send_beat(sme_pkg::OP_ASSIGN, pick_value(), 6'($urandom));
            send_beat(sme_pkg::OP_PUSHV, pick_value(), v);
            send_beat(sme_pkg::OP_EVAL, pick_value(), 6'($urandom));
            send_beat($urandom_range(1) ? sme_pkg::OP_PRINT : sme_pkg::OP_ADD,
                      pick_value(), 6'($urandom));
         end else begin
            random_op();
         end
      end
      drain();
   endtask

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
            long_hold = 1'b0;
         end else begin
            rsp_ready <= calm || $urandom_range(99) >= 20;
         end
      end
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         received++;
         if (rsp_print_valid) prints++;
         if (rsp_status != sme_pkg::ST_OK) faults++;
         if (pending_q.size() == 0) begin
            $error("result beat with nothing pending");
            errors++;
         end else begin
            want = pending_q.pop_front();
            if (rsp_status !== want.status) begin
               $error("status expected %0d got %0d", want.status, rsp_status);
               errors++;
            end
            if (rsp_print_valid !== want.print_valid) begin
               $error("print_valid expected %0d got %0d", want.print_valid, rsp_print_valid);
               errors++;
            end
            if (rsp_print_value !== want.print_value) begin
               $error("print_value expected %h got %h", want.print_value, rsp_print_value);
               errors++;
            end
            if (rsp_stack_depth !== want.depth) begin
               $error("stack_depth expected %0d got %0d", want.depth, rsp_stack_depth);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      req_valid = 1'b0;
      req_opcode = sme_pkg::OP_PUSHC;
      req_operand_value = 64'd0;
      req_var_index = 6'd0;
      reset = 1'b1;
      idle_cycles = 0;
      depth_m = 0;
      foreach (defined_m[i]) defined_m[i] = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_overflow();
      test_backpressure();
      calm = 1'b1;
      test_random(300);
      calm = 1'b0;
      test_random(650);
      repeat (100) @(posedge clock);
      $display("Ran %0d instructions, %0d results, %0d prints and %0d error statuses,",
               sent, received, prints, faults);
      $display("including stack overflow, a long output stall and a calm stretch.");
      if (errors == 0 && pending_q.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule

@@ filelist.f @@
src/sme_pkg.sv
src/sme_ram.sv
src/sme_datapath.sv
src/sme_ctrl.sv
src/stack_machine_evaluator.sv
bench/tb_stack_machine_evaluator.sv
